// ===== rtl/tes_pkg.sv =====
// Package: shared constants and codes for the tick event scheduler.
package tes_pkg;
    localparam int ENTRIES_DEF    = 16;
    localparam int DELAY_BITS_DEF = 24;
    localparam int ID_BITS_DEF    = 16;
    localparam int TAG_BITS_DEF   = 8;

    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_SCHED_ONE = 3'd1;
    localparam logic [2:0] CMD_SCHED_REP = 3'd2;
    localparam logic [2:0] CMD_CANC_ONE  = 3'd3;
    localparam logic [2:0] CMD_CANC_REP  = 3'd4;
    localparam logic [2:0] CMD_WAIT      = 3'd5;

    localparam logic [2:0] KIND_SCHEDULED = 3'd0;
    localparam logic [2:0] KIND_FIRED     = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_FULL      = 3'd4;
    localparam logic [2:0] KIND_TICK_DONE = 3'd5;
    localparam logic [2:0] KIND_WAIT      = 3'd6;
endpackage

// ===== rtl/tes_if.sv =====
// Interfaces: command and result channels.
interface tes_cmd_if #(
    parameter int DELAY_BITS = tes_pkg::DELAY_BITS_DEF,
    parameter int ID_BITS    = tes_pkg::ID_BITS_DEF,
    parameter int TAG_BITS   = tes_pkg::TAG_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            command;
    logic [DELAY_BITS-1:0] delay_ticks;
    logic [TAG_BITS-1:0]   handler_tag;
    logic [ID_BITS-1:0]    target_id;
    modport source (output valid, command, delay_ticks, handler_tag, target_id, input ready);
    modport sink   (input valid, command, delay_ticks, handler_tag, target_id, output ready);
endinterface

interface tes_res_if #(
    parameter int ID_BITS  = tes_pkg::ID_BITS_DEF,
    parameter int TAG_BITS = tes_pkg::TAG_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [2:0]          kind;
    logic [ID_BITS-1:0]  entry_id;
    logic [TAG_BITS-1:0] fired_tag;
    logic                wait_busy;
    logic                last;
    modport source (output valid, kind, entry_id, fired_tag, wait_busy, last, input ready);
    modport sink   (input valid, kind, entry_id, fired_tag, wait_busy, last, output ready);
endinterface

// ===== rtl/tick_event_scheduler_core.sv =====
// Top level: tick event scheduler with a slot table walked by a sequencer.
// A wait is answered from idle; a schedule or cancel scans the slots, and on a hit makes an
// age pass before its beat. A tick makes a countdown pass, emits fired one-shots and then
// repeats, frees fired one-shots with an age pass for each, and ends with a done beat.
// Throughput: one command at a time; the next is taken as the last beat is taken.
// Reset (rst_n, async, active low): all slots invalid, next id 1, wait count 0.
module tick_event_scheduler_core #(
    parameter int ENTRIES    = tes_pkg::ENTRIES_DEF,
    parameter int DELAY_BITS = tes_pkg::DELAY_BITS_DEF,
    parameter int ID_BITS    = tes_pkg::ID_BITS_DEF,
    parameter int TAG_BITS   = tes_pkg::TAG_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tes_cmd_if.sink   cmd,
    tes_res_if.source res
);
    localparam int SW = $clog2(ENTRIES);
    localparam int CW = SW + 1;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FIND  = 4'd1;  // free slot / cancel match scan
    localparam logic [3:0] ST_AGE   = 4'd2;  // age bump or rerank pass
    localparam logic [3:0] ST_DEC   = 4'd3;  // tick: countdown pass
    localparam logic [3:0] ST_EMIT1 = 4'd4;  // tick: one-shots by age, oldest first
    localparam logic [3:0] ST_EMIT2 = 4'd5;  // tick: repeats by age, newest first
    localparam logic [3:0] ST_FREE  = 4'd6;  // tick: free fired one-shots
    localparam logic [3:0] ST_OUT   = 4'd7;  // final beat
    localparam logic [3:0] ST_WAITO = 4'd8;  // beat pending in emit

    logic [3:0]            state_reg;
    logic [3:0]            ret_reg;
    logic [2:0]            cmd_reg;
    logic [DELAY_BITS-1:0] delay_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [ID_BITS-1:0]    tid_reg;
    logic [CW-1:0]         idx_reg;   // slot index
    logic [CW-1:0]         rank_reg;  // age rank being emitted
    logic [CW-1:0]         cnt_reg;   // valid count of the countdown pass
    logic                  hit_reg;
    logic [SW-1:0]         hit_slot_reg;

    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    fire_reg;
    logic                  rep_mem   [ENTRIES];
    logic [DELAY_BITS-1:0] rem_mem   [ENTRIES];
    logic [DELAY_BITS-1:0] rld_mem   [ENTRIES];
    logic [ID_BITS-1:0]    id_mem    [ENTRIES];
    logic [TAG_BITS-1:0]   tag_mem   [ENTRIES];
    logic [SW-1:0]         age_mem   [ENTRIES];

    logic [ID_BITS-1:0]    next_id_reg;
    logic [DELAY_BITS-1:0] wait_reg;

    logic                  ov_reg;
    logic [2:0]            ok_reg;
    logic [ID_BITS-1:0]    oid_reg;
    logic [TAG_BITS-1:0]   otag_reg;
    logic                  olast_reg;

    logic [SW-1:0] s;
    logic          s_end;
    logic [SW-1:0] s_age;
    logic [SW-1:0] hit_age;
    assign s       = idx_reg[SW-1:0];
    assign s_end   = (idx_reg == CW'(ENTRIES - 1));
    assign s_age   = age_mem[s];
    assign hit_age = age_mem[hit_slot_reg];

    logic out_free;
    assign out_free  = !ov_reg || res.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && out_free;

    assign res.valid     = ov_reg;
    assign res.kind      = ok_reg;
    assign res.entry_id  = oid_reg;
    assign res.fired_tag = otag_reg;
    assign res.wait_busy = (wait_reg != '0);
    assign res.last      = olast_reg;

    logic is_rep_cmd;
    assign is_rep_cmd = (cmd_reg == tes_pkg::CMD_SCHED_REP) ||
                        (cmd_reg == tes_pkg::CMD_CANC_REP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            valid_reg   <= '0;
            next_id_reg <= ID_BITS'(1);
            wait_reg    <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (ov_reg && res.ready)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.valid && cmd.ready)
                    begin
                        cmd_reg   <= cmd.command;
                        delay_reg <= cmd.delay_ticks;
                        tag_reg   <= cmd.handler_tag;
                        tid_reg   <= cmd.target_id;
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        cnt_reg   <= '0;
                        fire_reg  <= '0;
                        case (cmd.command)
                            tes_pkg::CMD_TICK:
                            begin
                                if (wait_reg != '0)
                                    wait_reg <= wait_reg - 1'b1;
                                state_reg <= ST_DEC;
                            end
                            tes_pkg::CMD_SCHED_ONE, tes_pkg::CMD_SCHED_REP,
                            tes_pkg::CMD_CANC_ONE, tes_pkg::CMD_CANC_REP:
                                state_reg <= ST_FIND;
                            tes_pkg::CMD_WAIT:
                            begin
                                wait_reg  <= cmd.delay_ticks;
                                ov_reg    <= 1'b1;
                                ok_reg    <= tes_pkg::KIND_WAIT;
                                oid_reg   <= '0;
                                otag_reg  <= '0;
                                olast_reg <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_FIND:
                begin
                    // schedule: lowest free slot; cancel: lowest matching slot
                    if (!hit_reg)
                    begin
                        if (cmd_reg == tes_pkg::CMD_SCHED_ONE ||
                            cmd_reg == tes_pkg::CMD_SCHED_REP)
                        begin
                            if (!valid_reg[s])
                            begin
                                hit_reg      <= 1'b1;
                                hit_slot_reg <= s;
                            end
                        end
                        else if (valid_reg[s] && rep_mem[s] == is_rep_cmd &&
                                 id_mem[s] == tid_reg)
                        begin
                            hit_reg      <= 1'b1;
                            hit_slot_reg <= s;
                        end
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (s_end)
                    begin
                        idx_reg <= '0;
                        if (!(hit_reg || (cmd_reg == tes_pkg::CMD_SCHED_ONE ||
                              cmd_reg == tes_pkg::CMD_SCHED_REP ? !valid_reg[s] :
                              (valid_reg[s] && rep_mem[s] == is_rep_cmd &&
                               id_mem[s] == tid_reg))))
                        begin
                            ok_reg    <= (cmd_reg == tes_pkg::CMD_SCHED_ONE ||
                                          cmd_reg == tes_pkg::CMD_SCHED_REP) ?
                                         tes_pkg::KIND_FULL : tes_pkg::KIND_NOT_FOUND;
                            oid_reg   <= '0;
                            otag_reg  <= '0;
                            olast_reg <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                            state_reg <= ST_AGE;
                    end
                end
                ST_AGE:
                begin
                    // ages are a dense rank, so one pass with the hit's age suffices
                    if (cmd_reg == tes_pkg::CMD_SCHED_ONE ||
                        cmd_reg == tes_pkg::CMD_SCHED_REP)
                    begin
                        if (valid_reg[s])
                            age_mem[s] <= s_age + 1'b1;
                    end
                    else if (valid_reg[s] && s != hit_slot_reg && s_age > hit_age)
                        age_mem[s] <= s_age - 1'b1;
                    idx_reg <= idx_reg + 1'b1;
                    if (s_end)
                    begin
                        if (cmd_reg == tes_pkg::CMD_TICK)
                        begin
                            // slot freed by the tick: resume the free scan there
                            idx_reg   <= CW'(hit_slot_reg);
                            state_reg <= ST_FREE;
                        end
                        else if (cmd_reg == tes_pkg::CMD_SCHED_ONE ||
                                 cmd_reg == tes_pkg::CMD_SCHED_REP)
                        begin
                            valid_reg[hit_slot_reg] <= 1'b1;
                            rep_mem[hit_slot_reg]   <= is_rep_cmd;
                            rem_mem[hit_slot_reg]   <= (!is_rep_cmd && delay_reg == '0) ?
                                                       DELAY_BITS'(1) : delay_reg;
                            rld_mem[hit_slot_reg]   <= delay_reg;
                            id_mem[hit_slot_reg]    <= next_id_reg;
                            tag_mem[hit_slot_reg]   <= tag_reg;
                            age_mem[hit_slot_reg]   <= '0;
                            next_id_reg <= (next_id_reg + 1'b1 == '0) ?
                                           ID_BITS'(1) : next_id_reg + 1'b1;
                            ok_reg    <= tes_pkg::KIND_SCHEDULED;
                            oid_reg   <= next_id_reg;
                            otag_reg  <= '0;
                            olast_reg <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            valid_reg[hit_slot_reg] <= 1'b0;
                            ok_reg    <= tes_pkg::KIND_CANCELLED;
                            oid_reg   <= id_mem[hit_slot_reg];
                            otag_reg  <= tag_mem[hit_slot_reg];
                            olast_reg <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_DEC:
                begin
                    if (valid_reg[s])
                    begin
                        if (rem_mem[s] <= DELAY_BITS'(1))
                        begin
                            fire_reg[s] <= 1'b1;
                            rem_mem[s]  <= rep_mem[s] ? rld_mem[s] : '0;
                        end
                        else
                            rem_mem[s] <= rem_mem[s] - 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (s_end)
                    begin
                        idx_reg   <= '0;
                        rank_reg  <= cnt_reg + CW'(valid_reg[s]) - 1'b1;
                        state_reg <= (cnt_reg + CW'(valid_reg[s]) == '0) ?
                                     ST_FREE : ST_EMIT1;
                    end
                end
                ST_EMIT1, ST_EMIT2:
                begin
                    // walk ranks; per rank scan all slots (ranks are unique)
                    if (valid_reg[s] && fire_reg[s] && s_age == rank_reg[SW-1:0] &&
                        rep_mem[s] == (state_reg == ST_EMIT2))
                    begin
                        ov_reg    <= 1'b1;
                        ok_reg    <= tes_pkg::KIND_FIRED;
                        oid_reg   <= id_mem[s];
                        otag_reg  <= tag_mem[s];
                        olast_reg <= 1'b0;
                        ret_reg   <= state_reg;
                        state_reg <= ST_WAITO;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (s_end)
                    begin
                        idx_reg <= '0;
                        if (state_reg == ST_EMIT1)
                        begin
                            if (rank_reg == '0)
                            begin
                                // repeats walk upwards from the newest rank
                                rank_reg <= '0;
                                if (!(valid_reg[s] && fire_reg[s] && rep_mem[s] == 1'b0 &&
                                      s_age == rank_reg[SW-1:0]))
                                    state_reg <= ST_EMIT2;
                                ret_reg <= ST_EMIT2;
                            end
                            else
                                rank_reg <= rank_reg - 1'b1;
                        end
                        else
                        begin
                            rank_reg <= rank_reg + 1'b1;
                            if (rank_reg == cnt_reg - 1'b1)
                            begin
                                if (!(valid_reg[s] && fire_reg[s] && rep_mem[s] &&
                                      s_age == rank_reg[SW-1:0]))
                                    state_reg <= ST_FREE;
                                ret_reg <= ST_FREE;
                            end
                        end
                    end
                end
                ST_WAITO:
                begin
                    if (res.ready)
                        state_reg <= ret_reg;
                end
                ST_FREE:
                begin
                    // free fired one-shots, closing the age gap with a full pass for each
                    if (valid_reg[s] && fire_reg[s] && !rep_mem[s])
                    begin
                        valid_reg[s] <= 1'b0;
                        hit_slot_reg <= s;
                        hit_reg      <= 1'b1;
                        idx_reg      <= '0;
                        state_reg    <= ST_AGE;
                        cmd_reg      <= tes_pkg::CMD_TICK;
                        fire_reg[s]  <= 1'b0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (s_end)
                        begin
                            ok_reg    <= tes_pkg::KIND_TICK_DONE;
                            oid_reg   <= '0;
                            otag_reg  <= '0;
                            olast_reg <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // a pending beat is held until it is taken, never dropped
    property p_no_overwrite;
        @(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> res.valid;
    endproperty
    assert property (p_no_overwrite) else $error("result beat dropped");

    property p_busy_not_ready;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd.ready;
    endproperty
    assert property (p_busy_not_ready) else $error("ready while busy");

    property p_fired_not_last;
        @(posedge clk) disable iff (!rst_n)
        (res.valid && res.kind == tes_pkg::KIND_FIRED) |-> !res.last;
    endproperty
    assert property (p_fired_not_last) else $error("fired beat marked last");
endmodule

// ===== tb/tb.sv =====
// Testbench for tick_event_scheduler_core: random and directed commands against a slot-table model.
`timescale 1ns / 100ps

module tb;
    localparam int NSLOT  = tes_pkg::ENTRIES_DEF;
    localparam int WD_MAX = 20000;

    // command codes with no meaning, which the block must drop
    localparam logic [2:0] CMD_NONE_A = 3'd6;
    localparam logic [2:0] CMD_NONE_B = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [23:0] dly;
        logic [7:0]  tag;
        logic [15:0] tid;
    } cmd_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] id;
        logic [7:0]  tag;
        logic        busy;
        logic        last;
    } res_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tes_cmd_if cmd_if();
    tes_res_if res_if();

    tick_event_scheduler_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    always #2 clk = ~clk;

    // Commands waiting to go out, and result beats the model says are due.
    cmd_beat_t pending_cmds[$];
    res_beat_t due_results[$];

    int  errors = 0;
    int  sched_count = 0;      // schedule commands queued so far, a bound on the ids handed out
    bit  quiet = 1'b0;         // no new idle gaps or stalls on either side once set
    int  gap_left = 0;
    int  stall_left = 0;
    int  idle_cycles = 0;

    // Scheduler model state.
    bit          m_valid[NSLOT];
    bit          m_rep[NSLOT];
    logic [23:0] m_left[NSLOT];
    logic [23:0] m_reload[NSLOT];
    logic [15:0] m_id[NSLOT];
    logic [7:0]  m_tag[NSLOT];
    int          m_age[NSLOT];
    logic [15:0] m_next_id;
    logic [23:0] m_wait;

    function automatic void add_cmd(logic [2:0] op, logic [23:0] dly, logic [7:0] tag,
                                    logic [15:0] tid);
        cmd_beat_t c;
        c.op = op; c.dly = dly; c.tag = tag; c.tid = tid;
        pending_cmds.push_back(c);
        if (op == tes_pkg::CMD_SCHED_ONE || op == tes_pkg::CMD_SCHED_REP)
            sched_count++;
    endfunction

    function automatic void expect_beat(logic [2:0] kind, logic [15:0] id, logic [7:0] tag,
                                        logic last);
        res_beat_t r;
        r.kind = kind; r.id = id; r.tag = tag; r.busy = (m_wait != 0); r.last = last;
        due_results.push_back(r);
    endfunction

    // Ages are kept as a dense rank 0..n-1 over live slots, 0 newest.
    function automatic void rerank_ages();
        int nr[NSLOT];
        for (int i = 0; i < NSLOT; i++)
        begin
            nr[i] = 0;
            if (m_valid[i])
                for (int j = 0; j < NSLOT; j++)
                    if (m_valid[j] && m_age[j] < m_age[i])
                        nr[i]++;
        end
        for (int i = 0; i < NSLOT; i++)
            if (m_valid[i])
                m_age[i] = nr[i];
    endfunction

    function automatic void apply_command(cmd_beat_t c);
        bit fire[NSLOT];
        int slot;
        bit rep;
        rep = (c.op == tes_pkg::CMD_SCHED_REP || c.op == tes_pkg::CMD_CANC_REP);
        slot = -1;
        case (c.op)
            tes_pkg::CMD_TICK:
            begin
                if (m_wait != 0)
                    m_wait--;
                for (int i = 0; i < NSLOT; i++)
                begin
                    fire[i] = 1'b0;
                    if (m_valid[i])
                    begin
                        if (m_left[i] <= 1)
                        begin
                            fire[i] = 1'b1;
                            m_left[i] = m_rep[i] ? m_reload[i] : 24'd0;
                        end
                        else
                            m_left[i]--;
                    end
                end
                // one-shots oldest first, then repeats newest first
                for (int r = NSLOT - 1; r >= 0; r--)
                    for (int i = 0; i < NSLOT; i++)
                        if (m_valid[i] && fire[i] && !m_rep[i] && m_age[i] == r)
                            expect_beat(tes_pkg::KIND_FIRED, m_id[i], m_tag[i], 1'b0);
                for (int r = 0; r < NSLOT; r++)
                    for (int i = 0; i < NSLOT; i++)
                        if (m_valid[i] && fire[i] && m_rep[i] && m_age[i] == r)
                            expect_beat(tes_pkg::KIND_FIRED, m_id[i], m_tag[i], 1'b0);
                for (int i = 0; i < NSLOT; i++)
                    if (m_valid[i] && fire[i] && !m_rep[i])
                        m_valid[i] = 1'b0;
                rerank_ages();
                expect_beat(tes_pkg::KIND_TICK_DONE, '0, '0, 1'b1);
            end
            tes_pkg::CMD_SCHED_ONE, tes_pkg::CMD_SCHED_REP:
            begin
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!m_valid[i])
                        slot = i;
                if (slot < 0)
                    expect_beat(tes_pkg::KIND_FULL, '0, '0, 1'b1);
                else
                begin
                    for (int i = 0; i < NSLOT; i++)
                        if (m_valid[i])
                            m_age[i]++;
                    m_valid[slot]  = 1'b1;
                    m_rep[slot]    = rep;
                    m_left[slot]   = (!rep && c.dly == 0) ? 24'd1 : c.dly;
                    m_reload[slot] = c.dly;
                    m_id[slot]     = m_next_id;
                    m_tag[slot]    = c.tag;
                    m_age[slot]    = 0;
                    m_next_id++;
                    if (m_next_id == 0)
                        m_next_id = 16'd1;
                    expect_beat(tes_pkg::KIND_SCHEDULED, m_id[slot], '0, 1'b1);
                end
            end
            tes_pkg::CMD_CANC_ONE, tes_pkg::CMD_CANC_REP:
            begin
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (m_valid[i] && m_rep[i] == rep && m_id[i] == c.tid)
                        slot = i;
                if (slot < 0)
                    expect_beat(tes_pkg::KIND_NOT_FOUND, '0, '0, 1'b1);
                else
                begin
                    m_valid[slot] = 1'b0;
                    rerank_ages();
                    expect_beat(tes_pkg::KIND_CANCELLED, m_id[slot], m_tag[slot], 1'b1);
                end
            end
            tes_pkg::CMD_WAIT:
            begin
                m_wait = c.dly;
                expect_beat(tes_pkg::KIND_WAIT, '0, '0, 1'b1);
            end
            default: ;   // unknown codes are dropped silently
        endcase
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
        errors++;
    endtask

    // Command driver: holds valid until the beat is taken, inserts idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid       <= 1'b0;
            cmd_if.command     <= tes_pkg::CMD_TICK;
            cmd_if.delay_ticks <= '0;
            cmd_if.handler_tag <= '0;
            cmd_if.target_id   <= '0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
                apply_command({cmd_if.command, cmd_if.delay_ticks, cmd_if.handler_tag,
                               cmd_if.target_id});
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_if.valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd_beat_t c;
                    c = pending_cmds.pop_front();
                    cmd_if.command     <= c.op;
                    cmd_if.delay_ticks <= c.dly;
                    cmd_if.handler_tag <= c.tag;
                    cmd_if.target_id   <= c.tid;
                    cmd_if.valid       <= 1'b1;
                    if (pending_cmds.size() < 40)
                        quiet = 1'b1;
                    if (!quiet && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 7);
                end
                else
                    cmd_if.valid <= 1'b0;
            end
        end
    end

    // Result sink: random stall bursts, then always ready near the end.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            res_if.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= 1'b1;
    end

    // Result monitor: each beat taken is matched against the oldest due result.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            res_beat_t want;
            if (due_results.size() == 0)
                report("unexpected beat, kind", 32'hx, 32'(res_if.kind));
            else
            begin
                want = due_results.pop_front();
                if (res_if.kind !== want.kind)
                    report("kind", 32'(want.kind), 32'(res_if.kind));
                if (res_if.entry_id !== want.id)
                    report("entry_id", 32'(want.id), 32'(res_if.entry_id));
                if (res_if.fired_tag !== want.tag)
                    report("fired_tag", 32'(want.tag), 32'(res_if.fired_tag));
                if (res_if.wait_busy !== want.busy)
                    report("wait_busy", 32'(want.busy), 32'(res_if.wait_busy));
                if (res_if.last !== want.last)
                    report("last", 32'(want.last), 32'(res_if.last));
            end
        end
    end

    // Watchdog: too long without any beat on either channel ends the run.
    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_MAX)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int pick;
        logic [23:0] dly;
        for (int i = 0; i < NSLOT; i++)
        begin
            m_valid[i] = 1'b0; m_rep[i] = 1'b0; m_left[i] = '0; m_reload[i] = '0;
            m_id[i] = '0; m_tag[i] = '0; m_age[i] = 0;
        end
        m_next_id = 16'd1;
        m_wait = '0;

        // Directed: zero and unit delays, ties, extremes, hits and misses.
        add_cmd(tes_pkg::CMD_SCHED_ONE, 24'd0, 8'hff, 16'h0);       // id 1, fires next tick
        add_cmd(tes_pkg::CMD_SCHED_ONE, 24'd1, 8'h00, 16'h0);       // id 2
        add_cmd(tes_pkg::CMD_SCHED_REP, 24'd0, 8'haa, 16'h0);       // id 3, every tick
        add_cmd(tes_pkg::CMD_SCHED_REP, 24'd1, 8'h55, 16'h0);       // id 4, every tick
        add_cmd(tes_pkg::CMD_SCHED_ONE, 24'd3, 8'h12, 16'h0);       // id 5, tie with id 6
        add_cmd(tes_pkg::CMD_SCHED_ONE, 24'd3, 8'h34, 16'h0);       // id 6
        add_cmd(tes_pkg::CMD_WAIT, 24'hffffff, 8'h00, 16'h0);
        repeat (4) add_cmd(tes_pkg::CMD_TICK, 24'd0, 8'h00, 16'h0);
        add_cmd(tes_pkg::CMD_CANC_REP, 24'd0, 8'h00, 16'd3);        // hit
        add_cmd(tes_pkg::CMD_CANC_REP, 24'd0, 8'h00, 16'd3);        // now a miss
        add_cmd(tes_pkg::CMD_CANC_ONE, 24'hffffff, 8'hff, 16'hffff);
        add_cmd(tes_pkg::CMD_SCHED_REP, 24'hffffff, 8'h81, 16'h0);  // id 7, never fires here
        add_cmd(tes_pkg::CMD_CANC_ONE, 24'd0, 8'h00, 16'd4);        // wrong type: miss
        add_cmd(tes_pkg::CMD_WAIT, 24'd0, 8'h00, 16'h0);
        add_cmd(CMD_NONE_A, 24'hffffff, 8'hff, 16'hffff);           // ignored
        add_cmd(CMD_NONE_B, 24'h0, 8'h0, 16'h0);                    // ignored
        add_cmd(tes_pkg::CMD_WAIT, 24'd2, 8'h00, 16'h0);
        add_cmd(tes_pkg::CMD_TICK, 24'd0, 8'h00, 16'h0);
        add_cmd(tes_pkg::CMD_CANC_REP, 24'd0, 8'h00, 16'd4);
        add_cmd(tes_pkg::CMD_TICK, 24'hffffff, 8'hff, 16'hffff);

        // Fill the table past capacity, then drain it with ticks.
        for (int k = 0; k < NSLOT + 1; k++)
            add_cmd(tes_pkg::CMD_SCHED_ONE, 24'($urandom_range(0, 3)), 8'($urandom), 16'h0);
        repeat (5) add_cmd(tes_pkg::CMD_TICK, 24'd0, 8'h00, 16'h0);
        add_cmd(tes_pkg::CMD_CANC_REP, 24'd0, 8'h00, 16'd7);

        // Random mix, mostly short delays so entries actually fire.
        for (int k = 0; k < 150; k++)
        begin
            pick = $urandom_range(0, 99);
            dly = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6));
            if (pick < 35)
                add_cmd(tes_pkg::CMD_TICK, 24'($urandom), 8'($urandom), 16'($urandom));
            else if (pick < 57)
                add_cmd(tes_pkg::CMD_SCHED_ONE, dly, 8'($urandom), 16'($urandom));
            else if (pick < 70)
                add_cmd(tes_pkg::CMD_SCHED_REP, dly, 8'($urandom), 16'($urandom));
            else if (pick < 88)
                add_cmd(($urandom_range(0, 1) == 0) ? tes_pkg::CMD_CANC_ONE :
                        tes_pkg::CMD_CANC_REP, 24'($urandom), 8'($urandom),
                        16'($urandom_range(1, sched_count + 1)));
            else if (pick < 92)
                add_cmd(($urandom_range(0, 1) == 0) ? tes_pkg::CMD_CANC_ONE :
                        tes_pkg::CMD_CANC_REP, 24'($urandom), 8'($urandom),
                        16'($urandom));
            else if (pick < 98)
                add_cmd(tes_pkg::CMD_WAIT, 24'($urandom_range(0, 4)), 8'($urandom),
                        16'($urandom));
            else
                add_cmd(($urandom_range(0, 1) == 0) ? CMD_NONE_A : CMD_NONE_B,
                        24'($urandom), 8'($urandom), 16'($urandom));
        end
        repeat (6) add_cmd(tes_pkg::CMD_TICK, 24'd0, 8'h00, 16'h0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_if.valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (errors == 0 && due_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
